@@ rtl/core/rrdc_pkg.sv @@
// shared types, constants and helpers for the route request duplicate cache
package rrdc_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int ADDR_W          = 32;
   localparam int ID_W            = 32;
   localparam int TIME_W          = 32;
   localparam int LIFE_W          = 16;
   localparam int OPER_W          = 2;
   localparam int COUNT_W         = 6;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LIFE_W-1:0]  LIFETIME_RESET = LIFE_W'(2800);
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

   localparam logic [OPER_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OPER_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OPER_W-1:0] OP_EXPIRE = 2'd2;

   typedef enum logic [1:0] {
      KIND_ADD,
      KIND_QUERY,
      KIND_EXPIRE,
      KIND_NOP
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [ADDR_W-1:0]  source;
      logic [ID_W-1:0]    request;
      logic [TIME_W-1:0]  now;
   } item_type;

   // one table entry as stored in the ram
   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  source;
      logic [ID_W-1:0]    request;
      logic [TIME_W-1:0]  expiry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // front to back: head of the request queue
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   // back to front: pop and clearing status
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } back_state_type;

   function automatic op_kind_type classify(input logic [OPER_W-1:0] oper);
      op_kind_type k;
      case (oper)
         OP_ADD:    k = KIND_ADD;
         OP_QUERY:  k = KIND_QUERY;
         OP_EXPIRE: k = KIND_EXPIRE;
         default:   k = KIND_NOP;
      endcase
      return k;
   endfunction

endpackage

@@ rtl/core/rrdc_ram.sv @@
// generic single write port ram with registered read
module rrdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/rrdc_front.sv @@
// front end: request intake, operation decode and a short request queue
module rrdc_front
   import rrdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPER_W-1:0]    req_operation,
   input  logic [ADDR_W-1:0]    req_source_address,
   input  logic [ID_W-1:0]      req_request_id,
   input  logic [TIME_W-1:0]    req_now,
   input  back_status_type      back_status,
   output queue_head_type       queue_head
);

   item_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;
   item_type          new_item;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH)) || back_status.clearing;
   assign push      = req_valid && !req_stall;
   assign pop       = back_status.pop && (count_ff != '0);

   always_comb begin
      new_item.kind    = classify(req_operation);
      new_item.source  = req_source_address;
      new_item.request = req_request_id;
      new_item.now     = req_now;
   end

   // pointer wrap for any queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign queue_head.valid = (count_ff != '0);
   assign queue_head.item  = queue_ff[rd_ptr_ff];

endmodule

@@ rtl/core/rrdc_back.sv @@
// back end: table scan engine, entry update and result register
module rrdc_back
   import rrdc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [LIFE_W-1:0]    path_lifetime,
   input  queue_head_type       queue_head,
   output back_status_type      back_status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic                 rsp_table_full_drop,
   output logic [COUNT_W-1:0]   rsp_removed_count
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               chk_valid_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   item_type           item_ff;
   logic               match_ff, match_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0] removed_ff, removed_in;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic               rsp_drop_ff;
   logic [COUNT_W-1:0] rsp_removed_ff;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   entry_type          ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          rd_entry;

   logic               hit;
   logic               is_free;
   logic               stale;
   logic               out_free;
   logic               do_insert;
   logic [TIME_W:0]    expiry_sum;
   logic [TIME_W-1:0]  expiry_sat;

   rrdc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // per-entry checks on the word read back
   assign hit     = chk_valid_ff && rd_entry.valid && (rd_entry.source == item_ff.source)
                    && (rd_entry.request == item_ff.request);
   assign is_free = chk_valid_ff && !rd_entry.valid;
   assign stale   = chk_valid_ff && rd_entry.valid && (rd_entry.expiry <= item_ff.now)
                    && (item_ff.kind == KIND_EXPIRE);

   assign expiry_sum = {1'b0, item_ff.now} + (TIME_W + 1)'(path_lifetime);
   assign expiry_sat = expiry_sum[TIME_W] ? '1 : expiry_sum[TIME_W-1:0];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign do_insert = (item_ff.kind == KIND_ADD) && !match_ff && free_found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == IDX_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (queue_head.valid) begin
               state_in = (queue_head.item.kind == KIND_NOP) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == IDX_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine: ram writes, queue pop and clearing status
   always_comb begin
      ram_we               = 1'b0;
      ram_waddr            = chk_idx_ff;
      ram_wdata            = rd_entry;
      ram_wdata.valid      = 1'b0;
      back_status.pop      = 1'b0;
      back_status.clearing = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            back_status.clearing = 1'b1;
            ram_we               = 1'b1;
            ram_waddr            = idx_ff;
            ram_wdata            = '0;
         end
         ST_IDLE: begin
            back_status.pop = queue_head.valid;
         end
         ST_SCAN, ST_DRAIN: begin
            ram_we = stale;
         end
         ST_DONE: begin
            if (out_free && do_insert) begin
               ram_we            = 1'b1;
               ram_waddr         = free_idx_ff;
               ram_wdata.valid   = 1'b1;
               ram_wdata.source  = item_ff.source;
               ram_wdata.request = item_ff.request;
               ram_wdata.expiry  = expiry_sat;
            end
         end
         default: ;
      endcase
   end

   // scan accumulators
   always_comb begin
      match_in      = match_ff | hit;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      removed_in    = removed_ff;
      if (is_free && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = chk_idx_ff;
      end
      if (stale && (removed_ff != COUNT_MAX)) begin
         removed_in = removed_ff + 1'b1;
      end
      if (state_ff == ST_IDLE) begin
         match_in      = 1'b0;
         free_found_in = 1'b0;
         removed_in    = '0;
      end
   end

   always_comb begin
      idx_in = '0;
      if ((state_ff == ST_CLEAR) || (state_ff == ST_SCAN)) begin
         idx_in = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         chk_valid_ff <= (state_ff == ST_SCAN);
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= idx_ff;
      match_ff      <= match_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      removed_ff    <= removed_in;
      if ((state_ff == ST_IDLE) && queue_head.valid) begin
         item_ff <= queue_head.item;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_found_ff   <= match_ff && ((item_ff.kind == KIND_ADD)
                                        || (item_ff.kind == KIND_QUERY));
         rsp_drop_ff    <= (item_ff.kind == KIND_ADD) && !match_ff && !free_found_ff;
         rsp_removed_ff <= (item_ff.kind == KIND_EXPIRE) ? removed_ff : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_table_full_drop = rsp_drop_ff;
   assign rsp_removed_count   = rsp_removed_ff;

endmodule

@@ rtl/core/route_request_duplicate_cache_core.sv @@
// top level of the route request duplicate cache
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   req     | in        | req_valid/req_stall  | operation, source_address, request_id, now
//   rsp     | out       | rsp_valid/rsp_stall  | found, table_full_drop, removed_count
//   csr     | in        | csr_valid/csr_ready  | path_lifetime
//
// add, query and expire each run these steps in the back end: pop the request, read every table
// entry from the ram, drain the read pipe and post the result
// unused operation codes skip the scan and go from the pop straight to posting the result
// the table ram has a single read port, so the entry scan sets the rate
// after reset a clearing pass writes zero to every ram entry; req_stall is high meanwhile
// a two-entry queue between front and back keeps intake going while the back end works
// the result register holds a response under rsp_stall; the back end waits in its done state
module route_request_duplicate_cache_core
   import rrdc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OPER_W-1:0]    req_operation,
   input  logic [ADDR_W-1:0]    req_source_address,
   input  logic [ID_W-1:0]      req_request_id,
   input  logic [TIME_W-1:0]    req_now,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic                 rsp_table_full_drop,
   output logic [COUNT_W-1:0]   rsp_removed_count,
   // lifetime register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LIFE_W-1:0]    csr_path_lifetime
);

   logic [LIFE_W-1:0] lifetime_ff;
   queue_head_type    queue_head;
   back_status_type   back_status;

   // lifetime register, writes always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFETIME_RESET;
      end else if (csr_valid && csr_ready) begin
         lifetime_ff <= csr_path_lifetime;
      end
   end

   // intake and decode
   rrdc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_source_address (req_source_address),
      .req_request_id     (req_request_id),
      .req_now            (req_now),
      .back_status        (back_status),
      .queue_head         (queue_head)
   );

   // table scan and update
   rrdc_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .path_lifetime       (lifetime_ff),
      .queue_head          (queue_head),
      .back_status         (back_status),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_table_full_drop (rsp_table_full_drop),
      .rsp_removed_count   (rsp_removed_count)
   );

endmodule
